// ----- src/fbse_pkg.sv -----
// Package for the five-band slew filter equalizer.
// Shared constants, the band coefficient table and a saturation helper.
// No dependencies.
package fbse_pkg;

  localparam int NUM_BANDS = 5;
  localparam int POLE_PAIRS_DEF = 4;
  localparam int SAMPLE_W = 24;
  localparam int STATE_W = 32;
  localparam int GAIN_W = 15;
  localparam int RATE_W = 16;
  localparam int MIX_W = 56;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_TOP   = 3'd0;
  localparam logic [2:0] REG_BAND5 = 3'd5;
  localparam logic [2:0] REG_RATE  = 3'd6;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd16384;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd27761;

  // band constants 0.564^c in Q0.16
  function automatic logic [15:0] band_k(input logic [2:0] b);
    case (b)
      3'd0: band_k = 16'd40278;
      3'd1: band_k = 16'd22075;
      3'd2: band_k = 16'd6262;
      3'd3: band_k = 16'd1881;
      3'd4: band_k = 16'd797;
      default: band_k = 16'd0;
    endcase
  endfunction

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [MIX_W-1:0] v);
    if (v > $signed({{(MIX_W-STATE_W){1'b0}}, 1'b0, {(STATE_W-1){1'b1}}}))
      sat32 = {1'b0, {(STATE_W-1){1'b1}}};
    else if (v < $signed({{(MIX_W-STATE_W){1'b1}}, 1'b1, {(STATE_W-1){1'b0}}}))
      sat32 = {1'b1, {(STATE_W-1){1'b0}}};
    else
      sat32 = v[STATE_W-1:0];
  endfunction

endpackage

// ----- src/five_band_slew_filter_eq.sv -----
// Five-band slew filter equalizer, top level.
// A new input sample is taken only in idle, once the last result is loaded
// into the output register. The single shared 35x18 multiplier walks every
// stage in turn, through the states RD, F, A, B, C, D, G and H.
// Reset (rst, synchronous): gains to 1.0, rate_base to 27761, all stage
// state reads as zero at once through per-entry valid bits.
module five_band_slew_filter_eq
  import fbse_pkg::*;
#(
  parameter int POLE_PAIRS = POLE_PAIRS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] sample_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] sample_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int STAGES = NUM_BANDS * POLE_PAIRS;
  localparam int ADDR_W = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int PASS_W = (POLE_PAIRS > 1) ? $clog2(POLE_PAIRS) : 1;
  localparam int PROD_W = 53;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_F    = 4'd2;
  localparam logic [3:0] ST_A    = 4'd3;
  localparam logic [3:0] ST_B    = 4'd4;
  localparam logic [3:0] ST_C    = 4'd5;
  localparam logic [3:0] ST_D    = 4'd6;
  localparam logic [3:0] ST_G    = 4'd7;
  localparam logic [3:0] ST_H    = 4'd8;
  localparam logic [3:0] ST_L    = 4'd9;
  localparam logic [3:0] ST_LA   = 4'd10;
  localparam logic [3:0] ST_MIX  = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  // ---------------- configuration registers ----------------
  logic [GAIN_W-1:0] gain [NUM_BANDS+1];  // index 0 = top band
  logic [RATE_W-1:0] rate_base;
  logic              cfg_we;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NUM_BANDS; i++) gain[i] <= GAIN_RESET;
      rate_base <= RATE_RESET;
    end else if (cfg_we) begin
      if (cfg_idx <= REG_BAND5) gain[cfg_idx] <= pwdata[GAIN_W-1:0];
      else if (cfg_idx == REG_RATE) rate_base <= pwdata[RATE_W-1:0];
    end
  end

  always_comb begin
    if (cfg_idx <= REG_BAND5) prdata = {17'd0, gain[cfg_idx]};
    else if (cfg_idx == REG_RATE) prdata = {16'd0, rate_base};
    else prdata = 32'd0;
  end

  // ---------------- stage state memory ----------------
  // each entry holds {slew, value}; valid bits stand in for the reset clear
  logic [2*STATE_W-1:0] mem [STAGES];
  logic [STAGES-1:0]    mem_vld;
  logic [2*STATE_W-1:0] rd_data;
  logic                 rd_vld;
  logic                 mem_we;
  logic [2*STATE_W-1:0] wr_data;

  logic [3:0]              state;
  logic [PASS_W-1:0]       pass_cnt;
  logic [2:0]              band_cnt;
  logic [ADDR_W-1:0]       addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= wr_data;
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= mem_vld[addr];
      if (mem_we) mem_vld[addr] <= 1'b1;
    end
  end

  // ---------------- datapath registers ----------------
  logic signed [STATE_W-1:0] x0;        // pass input (running result)
  logic signed [STATE_W-1:0] xs;        // current stage input
  logic signed [STATE_W-1:0] p, s;      // kept value and slew
  logic        [16:0]        f;         // stage coefficient
  logic signed [STATE_W-1:0] slew_n;
  logic signed [PROD_W-1:0]  t1;
  logic signed [STATE_W-1:0] out_prev;  // last stage output
  logic signed [STATE_W:0]   diff;      // band difference
  logic signed [MIX_W-1:0]   mix;
  logic signed [PROD_W-1:0]  prod;
  logic signed [34:0]        mul_a;
  logic signed [17:0]        mul_b;

  // shared multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_RD: begin
        mul_a = {19'd0, rate_base};
        mul_b = {2'd0, band_k(band_cnt)};
      end
      ST_A: begin
        mul_a = 35'(xs) - 35'(p) + 35'(s);
        mul_b = {1'b0, f};
      end
      ST_B: begin
        mul_a = 35'(xs);
        mul_b = {1'b0, f};
      end
      ST_C: begin
        mul_a = 35'(p) + 35'(s);
        mul_b = 18'sd65536 - $signed({1'b0, f});
      end
      ST_G: begin
        mul_a = 35'(diff);
        mul_b = {3'd0, gain[band_cnt]};
      end
      ST_L: begin
        mul_a = 35'(out_prev);
        mul_b = {3'd0, gain[NUM_BANDS]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) prod <= PROD_W'(mul_a * mul_b);

  // rounded stage results, half up
  logic signed [PROD_W-1:0]  coef_r;
  logic signed [PROD_W-1:0]  slew_r;
  logic signed [PROD_W:0]    val_r;
  logic signed [STATE_W-1:0] val_sat;
  logic signed [MIX_W-1:0]   mix_r;
  logic signed [STATE_W-1:0] acc_new;
  logic signed [STATE_W:0]   out_r;
  logic [SAMPLE_W-1:0]       out_sat;
  logic                      last_band;
  logic                      last_pass;

  assign coef_r  = (prod + PROD_W'(32768)) >>> 16;
  assign slew_r  = (prod + PROD_W'(65536)) >>> 17;
  assign val_r   = ((PROD_W+1)'(t1) + (PROD_W+1)'(prod) + (PROD_W+1)'(32768)) >>> 16;
  assign val_sat = sat32(MIX_W'(val_r));
  assign mix_r   = (mix + MIX_W'(8192)) >>> 14;
  assign acc_new = sat32(mix_r);
  assign out_r   = ((STATE_W+1)'(x0) + (STATE_W+1)'(64)) >>> 7;
  assign last_band = (band_cnt == 3'(NUM_BANDS - 1));
  assign last_pass = (pass_cnt == PASS_W'(POLE_PAIRS - 1));

  always_comb begin
    if (out_r > (STATE_W+1)'(8388607)) out_sat = 24'h7FFFFF;
    else if (out_r < -(STATE_W+1)'(8388608)) out_sat = 24'h800000;
    else out_sat = out_r[SAMPLE_W-1:0];
  end

  assign mem_we   = (state == ST_D);
  assign wr_data  = {slew_n, val_sat};
  assign s_tready = (state == ST_IDLE);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pass_cnt <= '0;
      band_cnt <= '0;
      addr     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the output request once taken, unless a new one loads now
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            x0       <= STATE_W'($signed(s_tdata)) <<< 7;
            xs       <= STATE_W'($signed(s_tdata)) <<< 7;
            mix      <= '0;
            pass_cnt <= '0;
            band_cnt <= '0;
            addr     <= '0;
            state    <= ST_RD;
          end
        end
        ST_RD: state <= ST_F;
        ST_F: begin
          // take coefficient and the kept state of this stage
          f     <= coef_r[16:0];
          p     <= rd_vld ? rd_data[STATE_W-1:0] : '0;
          s     <= rd_vld ? rd_data[2*STATE_W-1:STATE_W] : '0;
          state <= ST_A;
        end
        ST_A: state <= ST_B;
        ST_B: begin
          slew_n <= sat32(MIX_W'(slew_r));
          state  <= ST_C;
        end
        ST_C: begin
          t1    <= prod;
          state <= ST_D;
        end
        ST_D: begin
          // band below the previous stage, or top band on the first stage
          if (band_cnt == 3'd0) diff <= (STATE_W+1)'(x0) - (STATE_W+1)'(val_sat);
          else diff <= (STATE_W+1)'(out_prev) - (STATE_W+1)'(val_sat);
          out_prev <= val_sat;
          xs       <= val_sat;
          state    <= ST_G;
        end
        ST_G: state <= ST_H;
        ST_H: begin
          mix <= mix + MIX_W'(prod);
          if (last_band) begin
            state <= ST_L;
          end else begin
            band_cnt <= band_cnt + 3'd1;
            addr     <= addr + ADDR_W'(1);
            state    <= ST_RD;
          end
        end
        ST_L: state <= ST_LA;
        ST_LA: begin
          mix   <= mix + MIX_W'(prod);
          state <= ST_MIX;
        end
        ST_MIX: begin
          x0       <= acc_new;
          xs       <= acc_new;
          mix      <= '0;
          band_cnt <= '0;
          if (last_pass) begin
            state <= ST_OUT;
          end else begin
            pass_cnt <= pass_cnt + PASS_W'(1);
            addr     <= addr + ADDR_W'(1);
            state    <= ST_RD;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= out_sat;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(addr) < STAGES))
    else $error("stage address beyond memory");

  a_pass_range: assert property (@(posedge clk) disable iff (rst)
    (32'(pass_cnt) < POLE_PAIRS) && (band_cnt < 3'(NUM_BANDS)))
    else $error("pass or band counter out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output request changed");

  a_write_once: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> !mem_we)
    else $error("back-to-back stage writes");
`endif

endmodule
